// ===== design/tcpq_pkg.sv =====
// Shared types and codes for the two-class priority queue.
package tcpq_pkg;

    // Command codes carried in the input word
    typedef enum logic [1:0] {
        CMD_NORMAL = 2'd0,
        CMD_PREF   = 2'd1,
        CMD_SERVE  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Status codes carried in the output word
    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam int HIST_LEN = 3;

    // One queued entry: code, name handle and room
    typedef struct packed {
        logic [7:0]  room;
        logic [15:0] name;
        logic [39:0] code;
    } t_entry;

    typedef struct packed {
        t_cmd        cmd;
        logic [39:0] code_chars;
        logic [15:0] name_handle;
        logic [7:0]  dest_room;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [39:0] served_code;
        logic [15:0] served_name;
        logic [7:0]  served_room;
        logic [15:0] prev_name_first;
        logic [15:0] prev_name_second;
        logic [15:0] prev_name_third;
        logic [1:0]  prev_valid;
        logic [4:0]  pref_waiting;
        logic [4:0]  normal_waiting;
    } t_out_word;

endpackage

// ===== design/tcpq_cell.sv =====
// One queue cell: holds an entry and takes its neighbor's entry on a shift.
module tcpq_cell
    import tcpq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  logic   i_shift,
    input  t_entry i_entry,
    input  t_entry i_neighbor,
    output t_entry o_entry
);

    t_entry r_entry;

    // Load a new arrival, else advance toward the head on a pop
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end else if (i_shift) begin
            r_entry <= i_neighbor;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== design/tcpq_fifo.sv =====
// Shifting FIFO built from a row of cells; the head always sits in cell 0.
module tcpq_fifo
    import tcpq_pkg::*;
#(
    parameter int Depth = 16,
    localparam int CW = $clog2(Depth + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_pop,
    input  t_entry        i_entry,
    output t_entry        o_head,
    output logic [CW-1:0] o_count,
    output logic [CW-1:0] o_count_next
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_entry        w_cell [Depth];

    // Row of cells; the first free cell loads, all cells advance on a pop
    for (genvar g = 0; g < Depth; g++) begin : g_cell
        t_entry w_next;
        if (g + 1 < Depth) begin : g_mid
            assign w_next = w_cell[g + 1];
        end else begin : g_last
            assign w_next = w_cell[g];
        end
        tcpq_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_push && (r_count == CW'(g))),
            .i_shift    (i_pop),
            .i_entry    (i_entry),
            .i_neighbor (w_next),
            .o_entry    (w_cell[g])
        );
    end

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = r_count + CW'(1);
        end else if (i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head       = w_cell[0];
    assign o_count      = r_count;
    assign o_count_next = n_count;

endmodule

// ===== design/two_class_priority_queue_with_history_top.sv =====
// Top level of the two-class priority queue with served-name history.
//
// Input channel: one word per command (normal arrival, preferential arrival,
// serve next). Output channel: exactly one result word per command.
// Preferential entries are always served first; each class is served in
// arrival order. Each class lives in a row of QUEUE_DEPTH cells whose head
// is cell 0, so a serve reads a fixed cell and the row advances by one.
// The result word is registered and appears in the cycle after the command is taken.
// Throughput: one command per cycle unless the output stalls; the output register
// frees in the same cycle its word is taken, so an unstalled receiver sees no gaps.
// A stalled output holds its word and raises o_in_stall until it is taken.
// Arrival into a full class is dropped with status full; a serve on two empty
// classes reports empty. The result also shows the last three served names
// as they stood before the command.
// Reset (synchronous, active low) empties both classes, clears the history
// and drops any pending result word. No clearing pass is needed.
module two_class_priority_queue_with_history_top
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          w_accept;
    logic          w_push_pref;
    logic          w_push_norm;
    logic          w_pop_pref;
    logic          w_pop_norm;
    t_entry        w_new_entry;
    t_entry        w_pref_head;
    t_entry        w_norm_head;
    logic [CW-1:0] w_pref_count;
    logic [CW-1:0] w_norm_count;
    logic [CW-1:0] w_pref_next;
    logic [CW-1:0] w_norm_next;
    logic          w_pref_full;
    logic          w_norm_full;

    logic [15:0]   r_hist [HIST_LEN];
    logic [1:0]    r_hist_cnt;
    logic          r_out_valid;
    t_out_word     r_out_word;
    t_out_word     n_out_word;

    // Take a word when the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_new_entry = '{room: i_in_word.dest_room, name: i_in_word.name_handle,
                           code: i_in_word.code_chars};
    assign w_pref_full = (w_pref_count == CW'(QUEUE_DEPTH));
    assign w_norm_full = (w_norm_count == CW'(QUEUE_DEPTH));

    // Decode the command into queue actions
    always_comb begin
        w_push_pref = 1'b0;
        w_push_norm = 1'b0;
        w_pop_pref  = 1'b0;
        w_pop_norm  = 1'b0;
        if (w_accept) begin
            unique case (i_in_word.cmd)
                CMD_NORMAL: w_push_norm = !w_norm_full;
                CMD_PREF:   w_push_pref = !w_pref_full;
                CMD_SERVE: begin
                    w_pop_pref = (w_pref_count != '0);
                    w_pop_norm = (w_pref_count == '0) && (w_norm_count != '0);
                end
                default: ;
            endcase
        end
    end

    tcpq_fifo #(.Depth(QUEUE_DEPTH)) u_pref (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_pref),
        .i_pop        (w_pop_pref),
        .i_entry      (w_new_entry),
        .o_head       (w_pref_head),
        .o_count      (w_pref_count),
        .o_count_next (w_pref_next)
    );

    tcpq_fifo #(.Depth(QUEUE_DEPTH)) u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_norm),
        .i_pop        (w_pop_norm),
        .i_entry      (w_new_entry),
        .o_head       (w_norm_head),
        .o_count      (w_norm_count),
        .o_count_next (w_norm_next)
    );

    // Build the result word
    always_comb begin
        n_out_word                  = '0;
        n_out_word.prev_name_first  = r_hist[0];
        n_out_word.prev_name_second = r_hist[1];
        n_out_word.prev_name_third  = r_hist[2];
        n_out_word.prev_valid       = r_hist_cnt;
        n_out_word.pref_waiting     = 5'(w_pref_next);
        n_out_word.normal_waiting   = 5'(w_norm_next);
        unique case (i_in_word.cmd)
            CMD_NORMAL: n_out_word.status = w_norm_full ? ST_FULL : ST_ACCEPTED;
            CMD_PREF:   n_out_word.status = w_pref_full ? ST_FULL : ST_ACCEPTED;
            CMD_SERVE: begin
                if (w_pop_pref) begin
                    n_out_word.status      = ST_SERVED;
                    n_out_word.served_code = w_pref_head.code;
                    n_out_word.served_name = w_pref_head.name;
                    n_out_word.served_room = w_pref_head.room;
                end else if (w_pop_norm) begin
                    n_out_word.status      = ST_SERVED;
                    n_out_word.served_code = w_norm_head.code;
                    n_out_word.served_name = w_norm_head.name;
                    n_out_word.served_room = w_norm_head.room;
                end else begin
                    n_out_word.status = ST_EMPTY;
                end
            end
            default: n_out_word.status = ST_ACCEPTED;
        endcase
    end

    // Shift the served name into the history; names beyond the count stay zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0]  <= '0;
            r_hist[1]  <= '0;
            r_hist[2]  <= '0;
            r_hist_cnt <= '0;
        end else if (w_pop_pref || w_pop_norm) begin
            r_hist[0] <= n_out_word.served_name;
            r_hist[1] <= r_hist[0];
            r_hist[2] <= r_hist[1];
            if (r_hist_cnt != 2'(HIST_LEN)) begin
                r_hist_cnt <= r_hist_cnt + 2'd1;
            end
        end
    end

    // Hold the result word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== tb/two_class_priority_queue_with_history_top_test.sv =====
// Testbench for the two-class priority queue with served-name history.
`timescale 1ns / 1ps

module two_class_priority_queue_with_history_top_test;
    import tcpq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_CMDS = 1260;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    // Shadow state of the queue
    t_entry      pref_line[$];
    t_entry      normal_line[$];
    logic [15:0] served_names[HIST_LEN];
    logic [1:0]  served_depth;

    // Result words still owed by the block, oldest first
    t_out_word pending_results[$];

    int  cycle_count;
    int  mismatch_count;
    int  result_count;
    int  served_count;
    int  full_count;
    int  empty_count;
    bit  steady_flow;

    two_class_priority_queue_with_history_top #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [39:0] rand_code();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Compute the result word of one command and advance the shadow state
    function automatic t_out_word queue_step(t_in_word w);
        t_out_word r;
        t_entry    e;
        r = '0;
        r.prev_name_first  = (served_depth > 0) ? served_names[0] : 16'd0;
        r.prev_name_second = (served_depth > 1) ? served_names[1] : 16'd0;
        r.prev_name_third  = (served_depth > 2) ? served_names[2] : 16'd0;
        r.prev_valid       = served_depth;
        e.code = w.code_chars;
        e.name = w.name_handle;
        e.room = w.dest_room;
        case (w.cmd)
            CMD_PREF: begin
                if (pref_line.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pref_line.push_back(e);
                    r.status = ST_ACCEPTED;
                end
            end
            CMD_NORMAL: begin
                if (normal_line.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    normal_line.push_back(e);
                    r.status = ST_ACCEPTED;
                end
            end
            CMD_SERVE: begin
                if (pref_line.size() + normal_line.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = (pref_line.size() != 0) ? pref_line.pop_front()
                                                : normal_line.pop_front();
                    r.status      = ST_SERVED;
                    r.served_code = e.code;
                    r.served_name = e.name;
                    r.served_room = e.room;
                    served_names[2] = served_names[1];
                    served_names[1] = served_names[0];
                    served_names[0] = e.name;
                    if (served_depth < HIST_LEN) begin
                        served_depth = served_depth + 2'd1;
                    end
                end
            end
            default: begin
                r.status = ST_ACCEPTED;
            end
        endcase
        r.pref_waiting   = 5'(pref_line.size());
        r.normal_waiting = 5'(normal_line.size());
        return r;
    endfunction

    // Predict on each accepted command word, check each accepted result word
    always @(posedge i_clk) begin
        t_out_word want;
        string     bad;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(queue_step(i_in_word));
            end
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result word %h", o_out_word);
                    end
                end else begin
                    want = pending_results.pop_front();
                    bad  = "";
                    if (o_out_word.status !== want.status) bad = {bad, " status"};
                    if (o_out_word.served_code !== want.served_code) bad = {bad, " code"};
                    if (o_out_word.served_name !== want.served_name) bad = {bad, " name"};
                    if (o_out_word.served_room !== want.served_room) bad = {bad, " room"};
                    if (o_out_word.prev_name_first !== want.prev_name_first)
                        bad = {bad, " prev1"};
                    if (o_out_word.prev_name_second !== want.prev_name_second)
                        bad = {bad, " prev2"};
                    if (o_out_word.prev_name_third !== want.prev_name_third)
                        bad = {bad, " prev3"};
                    if (o_out_word.prev_valid !== want.prev_valid) bad = {bad, " prev_valid"};
                    if (o_out_word.pref_waiting !== want.pref_waiting)
                        bad = {bad, " pref_waiting"};
                    if (o_out_word.normal_waiting !== want.normal_waiting)
                        bad = {bad, " normal_waiting"};
                    if (bad != "") begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d wrong in%s: expected %h, got %h",
                                     result_count, bad, want, o_out_word);
                        end
                    end
                    if (want.status == ST_SERVED) served_count++;
                    if (want.status == ST_FULL) full_count++;
                    if (want.status == ST_EMPTY) empty_count++;
                end
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            n = idle_len();
            i_out_stall <= (n != 0);
            repeat (n) @(posedge i_clk);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Send one command word, after an optional gap, and hold it until taken
    task automatic send_cmd(input t_cmd c, input logic [39:0] code,
                            input logic [15:0] name, input logic [7:0] room);
        int       n;
        t_in_word w;
        n = idle_len();
        w.cmd         = c;
        w.code_chars  = code;
        w.name_handle = name;
        w.dest_room   = room;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random(input t_cmd c);
        send_cmd(c, rand_code(), 16'($urandom), 8'($urandom));
    endtask

    // Hold off the sender until every owed result word has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Field extremes, both classes, priority order, history fill and empty serves
    task automatic test_directed_basics();
        steady_flow = 1'b0;
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_NONE, '1, '1, '1);
        send_cmd(CMD_NORMAL, 40'h0, 16'h0000, 8'h00);
        send_cmd(CMD_NORMAL, 40'hFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
        send_cmd(CMD_PREF, 40'h70_3132_3334, 16'h1234, 8'h07);
        send_cmd(CMD_PREF, 40'hFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, '1, '1, '1);
        send_cmd(CMD_NORMAL, 40'h6E_3030_3031, 16'h00A5, 8'h80);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_PREF, 40'hAA_AAAA_AAAA, 16'h5555, 8'h55);
        send_cmd(CMD_NORMAL, 40'h55_5555_5555, 16'hAAAA, 8'hAA);
        send_cmd(CMD_PREF, 40'h01_0203_0405, 16'h8001, 8'h01);
        send_cmd(CMD_NONE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        send_cmd(CMD_SERVE, 40'h0, 16'h0, 8'h0);
        wait_drained();
    endtask

    // Fill each class past its depth, refill after serving, then drain
    task automatic test_class_full();
        int i;
        for (i = 0; i <= DEPTH; i++) send_random(CMD_PREF);
        for (i = 0; i <= DEPTH; i++) send_random(CMD_NORMAL);
        send_random(CMD_SERVE);
        send_random(CMD_PREF);
        send_random(CMD_PREF);
        for (i = 0; i < 3; i++) send_random(CMD_SERVE);
        for (i = 0; i < 3; i++) send_random(CMD_PREF);
        for (i = 0; i <= 2 * DEPTH; i++) send_random(CMD_SERVE);
        wait_drained();
    endtask

    // Mixed traffic in chunks, each with its own arrival bias and flow
    task automatic test_random_traffic();
        int sent;
        int chunk;
        int arrival_pct;
        int r;
        sent  = 0;
        chunk = 0;
        while (sent < RANDOM_CMDS) begin
            case ($urandom_range(0, 3))
                0: arrival_pct = 25;
                1: arrival_pct = 50;
                2: arrival_pct = 60;
                default: arrival_pct = 85;
            endcase
            steady_flow = ($urandom_range(0, 3) == 0);
            repeat (50) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_random(CMD_NONE);
                end else begin
                    if ($urandom_range(0, 99) < arrival_pct) begin
                        send_random($urandom_range(0, 1) ? CMD_PREF : CMD_NORMAL);
                    end else begin
                        send_random(CMD_SERVE);
                    end
                    sent++;
                end
            end
            chunk++;
            if (chunk % 5 == 0) wait_drained();
        end
        steady_flow = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        cycle_count    = 0;
        mismatch_count = 0;
        result_count   = 0;
        served_count   = 0;
        full_count     = 0;
        empty_count    = 0;
        steady_flow    = 1'b0;
        served_names   = '{default: 16'd0};
        served_depth   = 2'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_class_full();
        test_random_traffic();

        // Let the output settle before the verdict
        repeat (5) @(posedge i_clk);
        $display("checked %0d result words over %0d cycles", result_count, cycle_count);
        $display("served %0d entries, %0d arrivals refused full, %0d serves on empty",
                 served_count, full_count, empty_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, pending_results.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
